[rtl/core/nearest_palette_color_search_unit_defines.svh]
// Assertion macros shared by the nearest palette color search RTL.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_UNIT_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define NPCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define NPCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/npcs_pkg.sv]
// Package with types and constants of the nearest palette color search unit.
package npcs_pkg;

   localparam int PALETTE_ENTRIES_DEFAULT = 256;

   localparam int COLOR_W = 8;
   localparam int RGB_W   = 3 * COLOR_W;
   localparam int SQ_W    = 2 * COLOR_W;
   localparam int DIST_W  = 18;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_START      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_START    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_RESTRICT = 2'd2;

   localparam logic [COLOR_W-1:0] LOW_START_RESET      = 8'd2;
   localparam logic [COLOR_W-1:0] UPPER_START_RESET    = 8'd114;
   localparam logic               UPPER_RESTRICT_RESET = 1'b1;

   localparam logic [DIST_W-1:0] NO_MATCH_DIST = '1;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic clear;
      logic take;
   } dist_ctrl_type;

endpackage

[rtl/core/npcs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module npcs_ram #(
   parameter int DATA_W = 24,
   parameter int DEPTH  = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/npcs_dist.sv]
// Shared distance unit: squared RGB distance of one entry per cycle and running minimum.
`include "nearest_palette_color_search_unit_defines.svh"

module npcs_dist #(
   parameter int IDX_W = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  npcs_pkg::dist_ctrl_type       ctrl,
   input  logic [npcs_pkg::RGB_W-1:0]    query_color,
   input  logic [npcs_pkg::RGB_W-1:0]    entry_color,
   input  logic [IDX_W-1:0]              entry_index,
   output logic                          busy,
   output logic [IDX_W-1:0]              best_index,
   output logic [npcs_pkg::DIST_W-1:0]   best_distance
);

   localparam int CW = npcs_pkg::COLOR_W;

   logic [CW-1:0]               diff [3];
   logic [npcs_pkg::SQ_W-1:0]   sq_ff [3];
   logic [IDX_W-1:0]            sq_idx_ff;
   logic                        sq_vld_ff;
   logic                        found_ff;
   logic [npcs_pkg::DIST_W-1:0] best_dist_ff;
   logic [IDX_W-1:0]            best_idx_ff;
   logic [npcs_pkg::DIST_W-1:0] dist_sum;
   logic                        better;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (entry_color[c*CW +: CW] > query_color[c*CW +: CW]) begin
            diff[c] = entry_color[c*CW +: CW] - query_color[c*CW +: CW];
         end else begin
            diff[c] = query_color[c*CW +: CW] - entry_color[c*CW +: CW];
         end
      end
   end

   assign dist_sum = npcs_pkg::DIST_W'(sq_ff[0]) + npcs_pkg::DIST_W'(sq_ff[1])
                   + npcs_pkg::DIST_W'(sq_ff[2]);
   assign better   = !found_ff || (dist_sum < best_dist_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         sq_vld_ff <= ctrl.take;
         if (ctrl.clear) begin
            found_ff <= 1'b0;
         end else if (sq_vld_ff) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         sq_ff[c] <= diff[c] * diff[c];
      end
      sq_idx_ff <= entry_index;
      if (ctrl.clear) begin
         best_dist_ff <= npcs_pkg::NO_MATCH_DIST;
         best_idx_ff  <= '0;
      end else if (sq_vld_ff && better) begin
         best_dist_ff <= dist_sum;
         best_idx_ff  <= sq_idx_ff;
      end
   end

   assign busy          = sq_vld_ff;
   assign best_index    = best_idx_ff;
   assign best_distance = best_dist_ff;

   `NPCS_ASSERT_NEXT(a_best_never_grows, clock, reset, found_ff && !ctrl.clear,
      best_dist_ff <= $past(best_dist_ff), "running minimum distance increased")

endmodule

[rtl/core/nearest_palette_color_search_unit.sv]
// Top level of the nearest palette color search unit: sequencer, registers and ports.
//
// The req_ channel carries two kinds of transaction, chosen by req_tuser[0]. A write
// transaction stores one palette entry; it produces no response.
// A query transaction scans the palette from its start index to the last entry and
// produces one response on the rsp_ channel with the nearest index and its squared
// distance. The block reads one palette entry per cycle from its RAM and feeds it to
// a single distance-and-compare unit. req_tready stays low from acceptance until the
// response has been loaded into the output register.
// A query whose start index is not below PALETTE_ENTRIES answers index 0 and an
// all-ones distance without a scan.
// The response sits in an output register. While the receiver stalls, further write
// transactions are still accepted and a new query may scan; it waits at its end until
// the pending response has been taken.
// The user must write csr_ start registers only while idle; the block won't check.
// Reset restores the register defaults and empties the sequencer; palette contents
// are undefined until written.
`include "nearest_palette_color_search_unit_defines.svh"

module nearest_palette_color_search_unit #(
   parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
   input  logic [31:0]                         req_tdata,
   // cmd[0], upper_only[1]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // best_index[7:0], best_distance[25:8], zero[31:26]
   output logic [31:0]                         rsp_tdata,
   input  logic                                csr_we,
   input  logic [npcs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [npcs_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W = $clog2(PALETTE_ENTRIES);
   localparam int SW    = ((IDX_W > npcs_pkg::COLOR_W) ? IDX_W : npcs_pkg::COLOR_W) + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);
   localparam logic [SW-1:0]    ENTRIES  = SW'(PALETTE_ENTRIES);

   npcs_pkg::state_type state_ff, state_in;

   logic [npcs_pkg::COLOR_W-1:0] low_start_ff;
   logic [npcs_pkg::COLOR_W-1:0] upper_start_ff;
   logic                         restrict_ff;

   logic [IDX_W-1:0]             addr_ff, addr_in;
   logic                         rd_vld_ff;
   logic [IDX_W-1:0]             rd_idx_ff;
   logic [npcs_pkg::RGB_W-1:0]   color_ff;

   logic                         rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]                  rsp_data_ff;

   logic                         accept;
   logic                         is_query;
   logic [npcs_pkg::COLOR_W-1:0] start_sel;
   logic [SW-1:0]                start_ext;
   logic                         start_ok;
   logic [SW-1:0]                widx_ext;
   logic                         ram_we;
   logic                         ram_re;
   logic                         rsp_load;
   logic [npcs_pkg::RGB_W-1:0]   ram_rdata;
   npcs_pkg::dist_ctrl_type      dist_ctrl;
   logic                         dist_busy;
   logic [IDX_W-1:0]             best_idx;
   logic [npcs_pkg::DIST_W-1:0]  best_dist;
   logic [SW-1:0]                best_idx_ext;

   assign accept    = req_tvalid && req_tready;
   assign is_query  = (req_tuser[0] == npcs_pkg::CMD_QUERY);
   assign start_sel = (req_tuser[1] && restrict_ff) ? upper_start_ff : low_start_ff;
   assign start_ext = SW'(start_sel);
   assign start_ok  = start_ext < ENTRIES;
   assign widx_ext  = SW'(req_tdata[7:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_start_ff   <= npcs_pkg::LOW_START_RESET;
         upper_start_ff <= npcs_pkg::UPPER_START_RESET;
         restrict_ff    <= npcs_pkg::UPPER_RESTRICT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            npcs_pkg::CSR_LOW_START: begin
               low_start_ff <= csr_wdata;
            end
            npcs_pkg::CSR_UPPER_START: begin
               upper_start_ff <= csr_wdata;
            end
            npcs_pkg::CSR_UPPER_RESTRICT: begin
               restrict_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            if (req_tvalid && is_query) begin
               state_in = start_ok ? npcs_pkg::ST_SCAN : npcs_pkg::ST_FINISH;
            end
         end
         npcs_pkg::ST_SCAN: begin
            if (addr_ff == LAST_IDX) begin
               state_in = npcs_pkg::ST_DRAIN;
            end
         end
         npcs_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !dist_busy) begin
               state_in = npcs_pkg::ST_FINISH;
            end
         end
         npcs_pkg::ST_FINISH: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = npcs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npcs_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready      = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      rsp_load        = 1'b0;
      dist_ctrl.clear = 1'b0;
      dist_ctrl.take  = rd_vld_ff;
      case (state_ff)
         npcs_pkg::ST_IDLE: begin
            req_tready      = 1'b1;
            ram_we          = req_tvalid && !is_query && (widx_ext < ENTRIES);
            dist_ctrl.clear = req_tvalid && is_query;
         end
         npcs_pkg::ST_SCAN: begin
            ram_re = 1'b1;
         end
         npcs_pkg::ST_FINISH: begin
            rsp_load = !rsp_tvalid_ff || rsp_tready;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      addr_in = addr_ff;
      if (accept && is_query) begin
         addr_in = start_ext[IDX_W-1:0];
      end else if (ram_re) begin
         addr_in = addr_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= npcs_pkg::ST_IDLE;
         rd_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rd_vld_ff     <= ram_re;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign best_idx_ext = SW'(best_idx);

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      rd_idx_ff <= addr_ff;
      if (accept && is_query) begin
         color_ff <= req_tdata[31:8];
      end
      if (rsp_load) begin
         rsp_data_ff <= {6'd0, best_dist, best_idx_ext[7:0]};
      end
   end

   npcs_ram #(
      .DATA_W (npcs_pkg::RGB_W),
      .DEPTH  (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (widx_ext[IDX_W-1:0]),
      .wr_data (req_tdata[31:8]),
      .rd_en   (ram_re),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   npcs_dist #(
      .IDX_W (IDX_W)
   ) u_dist (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (dist_ctrl),
      .query_color   (color_ff),
      .entry_color   (ram_rdata),
      .entry_index   (rd_idx_ff),
      .busy          (dist_busy),
      .best_index    (best_idx),
      .best_distance (best_dist)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `NPCS_ASSERT_NEXT(a_read_only_in_scan, clock, reset, state_ff != npcs_pkg::ST_SCAN,
      !rd_vld_ff, "palette read issued outside the scan")
   `NPCS_ASSERT_SAME(a_finish_pipe_empty, clock, reset, state_ff == npcs_pkg::ST_FINISH,
      !rd_vld_ff && !dist_busy, "result taken while distance pipeline still busy")
   `NPCS_ASSERT_NEXT(a_query_leaves_idle, clock, reset, accept && is_query,
      state_ff != npcs_pkg::ST_IDLE, "accepted query did not start a search")

endmodule
